// ===== src/arqrto_pkg.sv =====
package arqrto_pkg;

  localparam int unsigned RttW   = 24;
  localparam int unsigned RtoW   = 16;
  localparam int unsigned WinW   = 16;
  localparam int unsigned IvlW   = 13;
  localparam int unsigned IncrW  = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Serial divider: quotient of mss*mss by the increment
  localparam int unsigned DivNumW = 2 * WinW;
  localparam int unsigned DivCntW = $clog2(DivNumW);

  localparam logic [RtoW-1:0]  RtoCeiling     = 16'd60000;
  localparam logic [RtoW-1:0]  RtoReset       = 16'd200;
  localparam logic [WinW-1:0]  ThreshFloor    = 16'd2;
  localparam logic [WinW-1:0]  ThreshReset    = 16'd2;
  localparam logic [WinW-1:0]  PeerReset      = 16'd32;
  localparam logic [RtoW-1:0]  MinRtoReset    = 16'd100;
  localparam logic [IvlW-1:0]  IntervalReset  = 13'd100;
  localparam logic [WinW-1:0]  MssReset       = 16'd1376;
  localparam logic [WinW-1:0]  MaxSndReset    = 16'd32;
  localparam logic [IncrW-1:0] IncrMax        = {IncrW{1'b1}};

  typedef enum logic [1:0] {
    OpRttSample = 2'd0,
    OpBatchEnd  = 2'd1,
    OpFlushEnd  = 2'd2,
    OpNone      = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinRto    = 3'd0,
    CfgInterval  = 3'd1,
    CfgMss       = 3'd2,
    CfgMaxSndWnd = 3'd3,
    CfgNoCwnd    = 3'd4,
    CfgFastCnt   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/arqrto_div.sv =====
module arqrto_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [arqrto_pkg::DivNumW-1:0] dividend_i,
  input  logic [arqrto_pkg::IncrW-1:0]   divisor_i,
  output arqrto_pkg::div_stat_t          stat_o,
  output logic [arqrto_pkg::DivNumW-1:0] quotient_o
);
  import arqrto_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] dvd_q, dvd_d;

  logic [DivNumW:0]   shifted;
  logic [DivNumW:0]   diff;
  logic               ge;

  // restoring division, one quotient bit per cycle; quotient shifts into dvd_q
  assign shifted = {rem_q, dvd_q[DivNumW-1]};
  assign ge      = IncrW'(shifted) >= divisor_i;
  assign diff    = shifted - divisor_i[DivNumW:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivNumW-1:0] : shifted[DivNumW-1:0];
      dvd_d = {dvd_q[DivNumW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

// ===== src/arq_rto_and_congestion_window_core.sv =====
// RTO estimator and congestion window controller of a reliable datagram transport.
// Input channel (in_valid_i/in_ready_o) carries one event per transaction:
// an RTT sample, the end of a received batch or the end of a flush. Every
// event produces exactly one result transaction on the output channel
// (out_valid_o/out_ready_i): a snapshot of RTO, smoothed RTT, congestion
// window, slow-start threshold and effective send window after the update.
// Steps from acceptance to out_valid_o: an unknown opcode goes straight to the
// result step, a batch end without growth or in slow start passes the window
// step, an RTT sample the averaging and RTO steps, a flush end the cut and set
// steps; congestion avoidance also waits for the serial radix-2 divider that
// forms mss*mss/increment. One event is worked at a time; in_ready_o is high
// only while the sequencer is idle. The result sits in an output register: if
// the receiver stalls, the sequencer holds in its final step until the register
// frees up. Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i),
// to be written only while idle; the block itself does not enforce this. Reset
// returns the configuration registers to their defaults and the state to RTO 200,
// threshold 2, peer window 32, smoothed RTT, deviation, cwnd and increment zero.
module arq_rto_and_congestion_window_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arqrto_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [arqrto_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic [arqrto_pkg::RttW-1:0]     rtt_sample_i,
  input  logic [arqrto_pkg::WinW-1:0]     remote_window_i,
  input  logic                            una_advanced_i,
  input  logic                            had_fast_resend_i,
  input  logic                            had_timeout_i,
  input  logic [arqrto_pkg::WinW-1:0]     inflight_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [arqrto_pkg::RtoW-1:0]     retransmit_timeout_o,
  output logic [arqrto_pkg::RttW-1:0]     smoothed_rtt_o,
  output logic [arqrto_pkg::WinW-1:0]     congestion_window_o,
  output logic [arqrto_pkg::WinW-1:0]     slow_start_threshold_o,
  output logic [arqrto_pkg::WinW-1:0]     send_window_o
);
  import arqrto_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_RTT_AVG = 10'b00_0000_0010,
    S_RTT_RTO = 10'b00_0000_0100,
    S_WIN     = 10'b00_0000_1000,
    S_DIV     = 10'b00_0001_0000,
    S_GROW    = 10'b00_0010_0000,
    S_CHK     = 10'b00_0100_0000,
    S_FL_CUT  = 10'b00_1000_0000,
    S_FL_SET  = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [RtoW-1:0] min_rto_q;
  logic [IvlW-1:0] interval_q;
  logic [WinW-1:0] mss_q;
  logic [WinW-1:0] max_snd_q;
  logic            no_cwnd_q;
  logic [WinW-1:0] fast_cnt_q;

  // transport state
  logic [RttW-1:0]  srtt_q, srtt_d;
  logic [RttW-1:0]  dev_q, dev_d;
  logic [RtoW-1:0]  rto_q, rto_d;
  logic [WinW-1:0]  cwnd_q, cwnd_d;
  logic [IncrW-1:0] incr_q, incr_d;
  logic [WinW-1:0]  ss_q, ss_d;
  logic [WinW-1:0]  peer_q, peer_d;
  logic [WinW-1:0]  eff_q, eff_d;

  // captured event
  logic [1:0]      op_q;
  logic [RttW-1:0] rtt_q;
  logic            adv_q;
  logic            fast_q;
  logic            tmo_q;
  logic [WinW-1:0] infl_q;

  // result register
  logic            out_valid_q, out_valid_d;
  logic [RtoW-1:0] res_rto_q;
  logic [RttW-1:0] res_srtt_q;
  logic [WinW-1:0] res_cwnd_q;
  logic [WinW-1:0] res_ss_q;
  logic [WinW-1:0] res_snd_q;
  logic            res_load;

  logic in_fire;
  logic fast_hit;

  // shared multiplier, one product per step
  logic [WinW:0]     mul_a;
  logic [2*WinW:0]   mul_p;
  logic [2*WinW:0]   chk_q, chk_d;

  logic               div_start;
  div_stat_t          div_stat;
  logic [DivNumW-1:0] div_quo;

  // RTT datapath
  logic [RttW-1:0]   rtt_delta;
  logic [RttW+1:0]   dev_sum;
  logic [RttW+2:0]   srtt_sum;
  logic [RttW-1:0]   srtt_avg;
  logic [RttW+1:0]   dev4;
  logic [IvlW-1:0]   dev_term;
  logic [RttW:0]     rto_sum;
  logic [RttW:0]     rto_lo;

  // window datapath
  logic [WinW-1:0]   snd_now;
  logic [IncrW:0]    incr_ss_sum;
  logic [IncrW-1:0]  quo_term;
  logic [IncrW+1:0]  incr_ca_sum;
  logic [WinW-1:0]   ss_fast;
  logic [WinW:0]     cwnd_fast;
  logic [WinW-1:0]   ss_tmo;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fast_hit   = fast_q && (fast_cnt_q != '0);
  assign res_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    snd_now = (max_snd_q < peer_q) ? max_snd_q : peer_q;
    if (!no_cwnd_q && (cwnd_q < snd_now)) begin
      snd_now = cwnd_q;
    end
  end

  always_comb begin
    rtt_delta = (rtt_q >= srtt_q) ? (rtt_q - srtt_q) : (srtt_q - rtt_q);
    dev_sum   = {1'b0, dev_q, 1'b0} + (RttW+2)'(dev_q) + (RttW+2)'(rtt_delta);
    srtt_sum  = {srtt_q, 3'b000} - (RttW+3)'(srtt_q) + (RttW+3)'(rtt_q);
    srtt_avg  = srtt_sum[RttW+2:3];
    dev4      = {dev_q, 2'b00};
    dev_term  = (dev4 < (RttW+2)'(interval_q)) ? dev4[IvlW-1:0] : interval_q;
    rto_sum   = (RttW+1)'(srtt_q) + (RttW+1)'(dev_term);
    rto_lo    = (rto_sum < (RttW+1)'(min_rto_q)) ? (RttW+1)'(min_rto_q) : rto_sum;
  end

  always_comb begin
    incr_ss_sum = (IncrW+1)'(incr_q) + (IncrW+1)'(mss_q);
    // a zero divisor only occurs with a zero segment size: quotient term is 0
    quo_term    = (incr_q == '0) ? '0 : IncrW'(div_quo);
    incr_ca_sum = (IncrW+2)'(incr_q) + (IncrW+2)'(quo_term) + (IncrW+2)'(mss_q >> 4);
    ss_fast     = (infl_q[WinW-1:1] < ThreshFloor[WinW-2:0]) ? ThreshFloor
                                                              : {1'b0, infl_q[WinW-1:1]};
    cwnd_fast   = (WinW+1)'(ss_fast) + (WinW+1)'(fast_cnt_q);
    ss_tmo      = (eff_q[WinW-1:1] < ThreshFloor[WinW-2:0]) ? ThreshFloor
                                                             : {1'b0, eff_q[WinW-1:1]};
  end

  always_comb begin
    unique case (state_q)
      S_WIN:    mul_a = {1'b0, mss_q};
      S_GROW:   mul_a = {1'b0, cwnd_q} + 1'b1;
      default:  mul_a = {1'b0, cwnd_q};
    endcase
    mul_p = mul_a * mss_q;
  end

  always_comb begin
    state_d     = state_q;
    srtt_d      = srtt_q;
    dev_d       = dev_q;
    rto_d       = rto_q;
    cwnd_d      = cwnd_q;
    incr_d      = incr_q;
    ss_d        = ss_q;
    peer_d      = peer_q;
    eff_d       = eff_q;
    chk_d       = chk_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (op_e'(opcode_i))
            OpRttSample: state_d = S_RTT_AVG;
            OpBatchEnd: begin
              peer_d  = remote_window_i;
              state_d = S_WIN;
            end
            OpFlushEnd: state_d = S_FL_CUT;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_RTT_AVG: begin
        if (srtt_q == '0) begin
          srtt_d = rtt_q;
          dev_d  = rtt_q >> 1;
        end else begin
          dev_d  = dev_sum[RttW+1:2];
          srtt_d = (srtt_avg == '0) ? RttW'(1) : srtt_avg;
        end
        state_d = S_RTT_RTO;
      end
      S_RTT_RTO: begin
        rto_d   = (rto_lo > (RttW+1)'(RtoCeiling)) ? RtoCeiling : rto_lo[RtoW-1:0];
        state_d = S_DONE;
      end
      S_WIN: begin
        if (!adv_q || (cwnd_q >= peer_q)) begin
          state_d = S_DONE;
        end else if (cwnd_q < ss_q) begin
          // slow start
          cwnd_d  = cwnd_q + 1'b1;
          incr_d  = incr_ss_sum[IncrW] ? IncrMax : incr_ss_sum[IncrW-1:0];
          state_d = S_DONE;
        end else begin
          if (incr_q < IncrW'(mss_q)) begin
            incr_d = IncrW'(mss_q);
          end
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_GROW;
        end
      end
      S_GROW: begin
        incr_d  = (incr_ca_sum[IncrW+1:IncrW] != 2'b00) ? IncrMax
                                                        : incr_ca_sum[IncrW-1:0];
        chk_d   = mul_p;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (IncrW'(chk_q) <= incr_q) begin
          cwnd_d = cwnd_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_FL_CUT: begin
        eff_d = snd_now;
        if (fast_hit) begin
          ss_d   = ss_fast;
          cwnd_d = cwnd_fast[WinW] ? {WinW{1'b1}} : cwnd_fast[WinW-1:0];
        end
        state_d = S_FL_SET;
      end
      S_FL_SET: begin
        if (tmo_q) begin
          ss_d   = ss_tmo;
          cwnd_d = WinW'(1);
          incr_d = IncrW'(mss_q);
        end else if (cwnd_q == '0) begin
          cwnd_d = WinW'(1);
          incr_d = IncrW'(mss_q);
        end else if (fast_hit) begin
          incr_d = IncrW'(mul_p);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  arqrto_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p[DivNumW-1:0]),
    .divisor_i  (incr_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rto_q  <= MinRtoReset;
      interval_q <= IntervalReset;
      mss_q      <= MssReset;
      max_snd_q  <= MaxSndReset;
      no_cwnd_q  <= 1'b0;
      fast_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMinRto:    min_rto_q  <= cfg_data_i;
        CfgInterval:  interval_q <= cfg_data_i[IvlW-1:0];
        CfgMss:       mss_q      <= cfg_data_i;
        CfgMaxSndWnd: max_snd_q  <= cfg_data_i;
        CfgNoCwnd:    no_cwnd_q  <= cfg_data_i[0];
        CfgFastCnt:   fast_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      srtt_q      <= '0;
      dev_q       <= '0;
      rto_q       <= RtoReset;
      cwnd_q      <= '0;
      incr_q      <= '0;
      ss_q        <= ThreshReset;
      peer_q      <= PeerReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      srtt_q      <= srtt_d;
      dev_q       <= dev_d;
      rto_q       <= rto_d;
      cwnd_q      <= cwnd_d;
      incr_q      <= incr_d;
      ss_q        <= ss_d;
      peer_q      <= peer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eff_q <= eff_d;
    chk_q <= chk_d;
    if (in_fire) begin
      op_q   <= opcode_i;
      rtt_q  <= rtt_sample_i;
      adv_q  <= una_advanced_i;
      fast_q <= had_fast_resend_i;
      tmo_q  <= had_timeout_i;
      infl_q <= inflight_count_i;
    end
    if (res_load) begin
      res_rto_q  <= rto_q;
      res_srtt_q <= srtt_q;
      res_cwnd_q <= cwnd_q;
      res_ss_q   <= ss_q;
      res_snd_q  <= snd_now;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign retransmit_timeout_o   = res_rto_q;
  assign smoothed_rtt_o         = res_srtt_q;
  assign congestion_window_o    = res_cwnd_q;
  assign slow_start_threshold_o = res_ss_q;
  assign send_window_o          = res_snd_q;

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("accepted a transaction while busy");

  a_rto_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rto_q <= RtoCeiling)
    else $error("RTO above ceiling");

  a_flush_cwnd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q == OpFlushEnd) |-> (cwnd_q != '0))
    else $error("congestion window zero after flush");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside its step");

endmodule
